// ===== rtl/caq_pkg.sv =====
`default_nettype none

package caq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int AW          = $clog2(QUEUE_DEPTH);
    localparam int CW          = $clog2(QUEUE_DEPTH + 1);

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Command types
    localparam logic [2:0] K_PLAY     = 3'd0;
    localparam logic [2:0] K_PAIR     = 3'd1;
    localparam logic [2:0] K_STOP     = 3'd2;
    localparam logic [2:0] K_STOPALL  = 3'd3;
    localparam logic [2:0] K_SHUTDOWN = 3'd4;
    localparam logic [2:0] K_VOLUME   = 3'd5;
    localparam logic [2:0] K_PAUSE    = 3'd6;
    // Unassigned code: stored as a plain command, never coalesced
    localparam logic [2:0] K_OTHER    = 3'd7;

    // Push status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_COAL = 2'd1;
    localparam logic [1:0] ST_DROP = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [2:0]  cmd_type;
        logic [15:0] cmd_id;
        logic [15:0] cmd_id2;
        logic [31:0] cmd_payload;
    } t_cmd_in;

    typedef struct packed {
        logic [1:0]  push_status;
        logic        pop_valid;
        logic [2:0]  head_type;
        logic [15:0] head_id;
        logic [15:0] head_id2;
        logic [31:0] head_payload;
        logic [31:0] head_sequence;
        logic [5:0]  occupancy;
        logic [5:0]  peak_occupancy;
        logic [31:0] dropped_count;
        logic [31:0] coalesced_count;
    } t_cmd_out;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] pid;
        logic [15:0] sid;
        logic [31:0] data;
        logic [31:0] stamp;
    } t_entry;

    function automatic logic is_barrier(input logic [2:0] k);
        return (k == K_STOPALL) || (k == K_SHUTDOWN);
    endfunction

    function automatic logic concerns(input t_entry e, input logic [15:0] id);
        return !is_barrier(e.kind) && ((e.pid == id) || ((e.kind == K_PAIR) && (e.sid == id)));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/coalescing_audio_command_queue.sv =====
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    i_in_data  (caq_pkg::t_cmd_in)
// out       output     o_out_valid / i_out_stall  o_out_data (caq_pkg::t_cmd_out)
//
// A pop on a non-empty queue makes one pass over the entry RAM that shifts the
// queue down. A push makes a scan pass, a compaction pass for play, stop and
// play-pair, and an eviction pass on a full queue, each one RAM read per cycle;
// the unassigned code skips the scan. Stop-all and shutdown make no pass.
// Reset is synchronous, active low; RAM contents are not cleared.
// A finished transaction waits in the output register while the next one is taken.

module coalescing_audio_command_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire caq_pkg::t_cmd_in  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output caq_pkg::t_cmd_out      o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_PASS, S_FULL, S_APPEND, S_REPL, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        M_FIND, M_DEL, M_EVICT, M_POP
    } t_mode;

    t_state                    r_state;
    t_mode                     r_mode;
    caq_pkg::t_cmd_in          r_cmd;
    logic [caq_pkg::CW-1:0]    r_fill;
    logic [caq_pkg::CW-1:0]    r_peak;
    logic [31:0]               r_stamp;
    logic [31:0]               r_pushed;
    logic [31:0]               r_popped;
    logic [31:0]               r_coal;
    logic [31:0]               r_dropped;
    logic [caq_pkg::CW-1:0]    r_rd;
    logic [caq_pkg::CW-1:0]    r_end;
    logic [caq_pkg::CW-1:0]    r_wr;
    logic [caq_pkg::CW-1:0]    r_pidx;
    logic                      r_pv;
    logic [caq_pkg::CW-1:0]    r_start;
    logic [caq_pkg::CW-1:0]    r_lc;
    logic                      r_lc_v;
    logic                      r_lc_m;
    logic                      r_removed;
    logic                      r_hit;
    logic [1:0]                r_status;
    logic                      r_popv;
    caq_pkg::t_entry           r_head;
    logic                      r_ovld;
    caq_pkg::t_cmd_out         r_out;

    caq_pkg::t_entry           rdata;
    caq_pkg::t_entry           new_entry;
    caq_pkg::t_entry           wdata;
    logic                      we;
    logic [caq_pkg::AW-1:0]    waddr;
    logic                      rd_issue;
    logic                      proc;
    logic                      keep;
    logic                      out_free;
    logic [caq_pkg::CW-1:0]    n_fill;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;
    assign out_free    = !r_ovld || !i_out_stall;
    assign n_fill      = r_fill + 1'b1;

    assign rd_issue = (r_state == S_PASS) && (r_rd < r_end);
    assign proc     = (r_state == S_PASS) && r_pv;

    // Decide whether the entry under process survives the pass
    always_comb begin
        case (r_mode)
            M_DEL:   keep = !(caq_pkg::concerns(rdata, r_cmd.cmd_id) ||
                              ((r_cmd.cmd_type == caq_pkg::K_PAIR) &&
                               caq_pkg::concerns(rdata, r_cmd.cmd_id2)));
            M_EVICT: keep = r_hit || !((rdata.kind == caq_pkg::K_VOLUME) ||
                                       (rdata.kind == caq_pkg::K_PAUSE));
            M_POP:   keep = (r_pidx != '0);
            default: keep = 1'b0;
        endcase
    end

    assign new_entry = '{kind:  r_cmd.cmd_type,
                         pid:   r_cmd.cmd_id,
                         sid:   r_cmd.cmd_id2,
                         data:  r_cmd.cmd_payload,
                         stamp: r_stamp + 32'd1};

    // Select the RAM write source
    always_comb begin
        we    = 1'b0;
        waddr = r_wr[caq_pkg::AW-1:0];
        wdata = rdata;
        if (proc && keep && (r_mode != M_FIND)) begin
            we = 1'b1;
        end else if (r_state == S_APPEND) begin
            we    = 1'b1;
            waddr = r_fill[caq_pkg::AW-1:0];
            wdata = new_entry;
        end else if (r_state == S_REPL) begin
            we    = 1'b1;
            waddr = r_lc[caq_pkg::AW-1:0];
            wdata = new_entry;
        end
    end

    caq_ram #(
        .WIDTH ($bits(caq_pkg::t_entry)),
        .DEPTH (caq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_issue),
        .i_raddr (r_rd[caq_pkg::AW-1:0]),
        .o_rdata (rdata)
    );

    // Sequencer, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= M_FIND;
            r_fill    <= '0;
            r_peak    <= '0;
            r_stamp   <= '0;
            r_pushed  <= '0;
            r_popped  <= '0;
            r_coal    <= '0;
            r_dropped <= '0;
            r_pv      <= 1'b0;
            r_ovld    <= 1'b0;
        end else begin
            if (r_ovld && !i_out_stall && (r_state != S_DONE)) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd     <= i_in_data;
                        r_status  <= caq_pkg::ST_OK;
                        r_popv    <= 1'b0;
                        r_head    <= '0;
                        r_removed <= 1'b0;
                        r_hit     <= 1'b0;
                        r_start   <= '0;
                        r_lc_v    <= 1'b0;
                        r_rd      <= '0;
                        r_wr      <= '0;
                        r_end     <= r_fill;
                        if (i_in_data.opcode == caq_pkg::OP_POP) begin
                            r_mode  <= M_POP;
                            r_state <= (r_fill == '0) ? S_DONE : S_PASS;
                        end else if (caq_pkg::is_barrier(i_in_data.cmd_type)) begin
                            r_removed <= (r_fill != '0);
                            r_fill    <= '0;
                            r_state   <= S_APPEND;
                        end else if (i_in_data.cmd_type == caq_pkg::K_OTHER) begin
                            r_state <= S_FULL;
                        end else begin
                            r_mode  <= M_FIND;
                            r_state <= S_PASS;
                        end
                    end
                end
                S_PASS: begin
                    // Issue the next read
                    if (rd_issue) begin
                        r_rd <= r_rd + 1'b1;
                    end
                    r_pv   <= rd_issue;
                    r_pidx <= r_rd;
                    // Process the entry read last cycle
                    if (proc) begin
                        if (r_mode == M_FIND) begin
                            if (caq_pkg::is_barrier(rdata.kind)) begin
                                r_start <= r_pidx + 1'b1;
                                r_lc_v  <= 1'b0;
                            end else if (caq_pkg::concerns(rdata, r_cmd.cmd_id)) begin
                                r_lc   <= r_pidx;
                                r_lc_v <= 1'b1;
                                r_lc_m <= (rdata.kind == r_cmd.cmd_type) &&
                                          (rdata.pid == r_cmd.cmd_id);
                            end
                        end else if (keep) begin
                            r_wr <= r_wr + 1'b1;
                        end else begin
                            case (r_mode)
                                M_DEL:   r_removed <= 1'b1;
                                M_EVICT: r_hit     <= 1'b1;
                                default: r_head    <= rdata;
                            endcase
                        end
                    end
                    // Close the pass
                    if (!rd_issue && !r_pv) begin
                        unique case (r_mode)
                            M_FIND: begin
                                if ((r_cmd.cmd_type == caq_pkg::K_VOLUME) ||
                                    (r_cmd.cmd_type == caq_pkg::K_PAUSE)) begin
                                    r_state <= (r_lc_v && r_lc_m) ? S_REPL : S_FULL;
                                end else begin
                                    r_mode <= M_DEL;
                                    r_rd   <= r_start;
                                    r_wr   <= r_start;
                                end
                            end
                            M_DEL: begin
                                r_fill  <= r_wr;
                                r_state <= S_FULL;
                            end
                            M_EVICT: begin
                                r_fill <= r_wr;
                                if (r_hit) begin
                                    r_state <= S_APPEND;
                                end else begin
                                    r_status <= caq_pkg::ST_DROP;
                                    r_state  <= S_DONE;
                                end
                            end
                            M_POP: begin
                                r_fill   <= r_wr;
                                r_popped <= r_popped + 32'd1;
                                r_popv   <= 1'b1;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_FULL: begin
                    if (r_fill >= caq_pkg::CW'(caq_pkg::QUEUE_DEPTH)) begin
                        r_dropped <= r_dropped + 32'd1;
                        r_mode    <= M_EVICT;
                        r_rd      <= '0;
                        r_wr      <= '0;
                        r_end     <= r_fill;
                        r_hit     <= 1'b0;
                        r_state   <= S_PASS;
                    end else begin
                        r_state <= S_APPEND;
                    end
                end
                S_APPEND: begin
                    r_stamp  <= r_stamp + 32'd1;
                    r_fill   <= n_fill;
                    r_pushed <= r_pushed + 32'd1;
                    if (r_peak < n_fill) begin
                        r_peak <= n_fill;
                    end
                    if (r_removed) begin
                        r_coal   <= r_coal + 32'd1;
                        r_status <= caq_pkg::ST_COAL;
                    end
                    r_state <= S_DONE;
                end
                S_REPL: begin
                    r_stamp  <= r_stamp + 32'd1;
                    r_coal   <= r_coal + 32'd1;
                    r_status <= caq_pkg::ST_COAL;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out.push_status     <= r_status;
                        r_out.pop_valid       <= r_popv;
                        r_out.head_type       <= r_head.kind;
                        r_out.head_id         <= r_head.pid;
                        r_out.head_id2        <= r_head.sid;
                        r_out.head_payload    <= r_head.data;
                        r_out.head_sequence   <= r_head.stamp;
                        r_out.occupancy       <= 6'(r_fill);
                        r_out.peak_occupancy  <= 6'(r_peak);
                        r_out.dropped_count   <= r_dropped;
                        r_out.coalesced_count <= r_coal;
                        r_ovld                <= 1'b1;
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= caq_pkg::CW'(caq_pkg::QUEUE_DEPTH))
        else $error("fill level beyond queue depth");

    a_peak_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_fill)
        else $error("watermark below fill level");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |-> (r_wr <= r_pidx))
        else $error("compaction write overtakes read");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !out_free) |=> (r_state == S_DONE))
        else $error("result lost while output stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/caq_ram.sv =====
`default_nettype none

module caq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
